// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Synthesis builds see empty macros.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define PFX_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// Antecedent implies consequent at the same edge.
`define PFX_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication failed");

// Antecedent implies consequent at the following edge.
`define PFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define PFX_ASSERT(lbl, clk, rst_n, prop)
`define PFX_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define PFX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hdl/pfx_pkg.sv -----
`default_nettype none

package pfx_pkg;

	localparam int WORD_W     = 32;
	localparam int DIV_CNT_W  = $clog2(WORD_W);

	// Symbol codes.
	localparam logic [7:0] SYM_ZERO  = 8'h30;
	localparam logic [7:0] SYM_NINE  = 8'h39;
	localparam logic [7:0] SYM_PLUS  = 8'h2B;
	localparam logic [7:0] SYM_MINUS = 8'h2D;
	localparam logic [7:0] SYM_STAR  = 8'h2A;
	localparam logic [7:0] SYM_SLASH = 8'h2F;

	typedef struct packed {
		logic [7:0] symbol;
		logic       last;
	} sym_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] value;
		logic                     div_zero;
		logic                     stack_error;
	} res_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_POP_B,
		S_WAIT_B,
		S_POP_A,
		S_WAIT_A,
		S_EXEC,
		S_DIV,
		S_DIV_FIX,
		S_PUSH,
		S_POP_F,
		S_WAIT_F,
		S_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- hdl/pfx_ram.sv -----
`default_nettype none

module pfx_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/postfix_expression_evaluator_top.sv -----
// Postfix expression evaluator. Each input word carries one ASCII symbol and a
// last flag. A digit pushes its value onto a stack of 32-bit words held in a
// RAM of STACK_DEPTH entries; any other symbol pops b and then a, and the
// operators + - * / push a op b with 32-bit wraparound (division truncates
// toward zero, division by zero pushes 0 and sets div_zero). Symbols that are
// neither digits nor operators consume two values and push nothing. Popping an
// empty stack yields 0 and pushing onto a full one drops the value; both set
// stack_error. On a word with last set, the symbol is processed, the top of the
// stack is popped and sent out as one result word with the sticky flags, and
// the stack and flags are cleared for the next expression. The block works on
// one symbol at a time and holds sym_stall high until it is done. A digit is
// pushed straight from the input word, and / is dominated by the 32-step
// restoring divider that produces one quotient bit per cycle; every pop also
// goes through a wait state for the registered read of the single-read-port
// stack RAM. A last symbol adds the final pop and the output register, plus
// any time the result side holds res_stall high while an earlier result is
// still waiting. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module postfix_expression_evaluator_top #(
	parameter int STACK_DEPTH = 128
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          sym_valid,
	output logic               sym_stall,
	input  wire pfx_pkg::sym_t sym_data,
	output logic               res_valid,
	input  wire logic          res_stall,
	output pfx_pkg::res_t      res_data
);

	import pfx_pkg::*;

	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

	// Control state.
	state_t             state_q, state_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               dz_q, dz_d;
	logic               err_q, err_d;
	logic               out_valid_q, out_valid_d;

	// Datapath registers.
	sym_t               sym_q, sym_d;
	logic [WORD_W-1:0]  a_q, a_d;
	logic [WORD_W-1:0]  b_q, b_d;
	logic [WORD_W-1:0]  res_q, res_d;
	logic [WORD_W-1:0]  div_rem_q, div_rem_d;
	logic [WORD_W-1:0]  div_quo_q, div_quo_d;
	logic [WORD_W-1:0]  div_mb_q, div_mb_d;
	logic               div_neg_q, div_neg_d;
	logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
	res_t               out_q, out_d;

	// Stack RAM port signals.
	logic               ram_we;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;
	logic [CNT_W-1:0]   cnt_dec;
	logic               stack_full;
	logic               stack_empty;
	logic               in_digit;

	// Divider step and multiplier.
	logic [WORD_W:0]    div_shift;
	logic [WORD_W:0]    div_diff;
	logic               div_ge;
	logic [WORD_W-1:0]  prod;

	assign cnt_dec     = count_q - CNT_W'(1);
	assign stack_full  = (count_q >= CNT_W'(STACK_DEPTH));
	assign stack_empty = (count_q == '0);
	assign in_digit    = (sym_data.symbol >= SYM_ZERO) && (sym_data.symbol <= SYM_NINE);

	assign div_shift = {div_rem_q, div_quo_q[WORD_W-1]};
	assign div_diff  = div_shift - {1'b0, div_mb_q};
	assign div_ge    = (div_shift >= {1'b0, div_mb_q});
	assign prod      = a_q * b_q;

	pfx_ram #(
		.WIDTH(WORD_W),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(ram_wdata),
		.raddr(cnt_dec[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	assign sym_stall = (state_q != S_IDLE);
	assign res_valid = out_valid_q;
	assign res_data  = out_q;

	always_comb begin
		state_d     = state_q;
		count_d     = count_q;
		dz_d        = dz_q;
		err_d       = err_q;
		out_valid_d = out_valid_q && res_stall;
		sym_d       = sym_q;
		a_d         = a_q;
		b_d         = b_q;
		res_d       = res_q;
		div_rem_d   = div_rem_q;
		div_quo_d   = div_quo_q;
		div_mb_d    = div_mb_q;
		div_neg_d   = div_neg_q;
		div_cnt_d   = div_cnt_q;
		out_d       = out_q;
		ram_we      = 1'b0;
		ram_wdata   = res_q;

		unique case (state_q)
			S_IDLE: begin
				if (sym_valid) begin
					sym_d = sym_data;
					if (in_digit) begin
						// Digits push straight from the input word.
						if (!stack_full) begin
							ram_we    = 1'b1;
							ram_wdata = WORD_W'(sym_data.symbol - SYM_ZERO);
							count_d   = count_q + CNT_W'(1);
						end else begin
							err_d = 1'b1;
						end
						state_d = sym_data.last ? S_POP_F : S_IDLE;
					end else begin
						state_d = S_POP_B;
					end
				end
			end
			S_POP_B: begin
				if (stack_empty) begin
					b_d     = '0;
					err_d   = 1'b1;
					state_d = S_POP_A;
				end else begin
					count_d = cnt_dec;
					state_d = S_WAIT_B;
				end
			end
			S_WAIT_B: begin
				b_d     = ram_rdata;
				state_d = S_POP_A;
			end
			S_POP_A: begin
				if (stack_empty) begin
					a_d     = '0;
					err_d   = 1'b1;
					state_d = S_EXEC;
				end else begin
					count_d = cnt_dec;
					state_d = S_WAIT_A;
				end
			end
			S_WAIT_A: begin
				a_d     = ram_rdata;
				state_d = S_EXEC;
			end
			S_EXEC: begin
				case (sym_q.symbol)
					SYM_PLUS: begin
						res_d   = a_q + b_q;
						state_d = S_PUSH;
					end
					SYM_MINUS: begin
						res_d   = a_q - b_q;
						state_d = S_PUSH;
					end
					SYM_STAR: begin
						res_d   = prod;
						state_d = S_PUSH;
					end
					SYM_SLASH: begin
						if (b_q == '0) begin
							dz_d    = 1'b1;
							res_d   = '0;
							state_d = S_PUSH;
						end else begin
							// Divide magnitudes, fix the sign at the end.
							div_quo_d = a_q[WORD_W-1] ? (WORD_W'(0) - a_q) : a_q;
							div_mb_d  = b_q[WORD_W-1] ? (WORD_W'(0) - b_q) : b_q;
							div_neg_d = a_q[WORD_W-1] ^ b_q[WORD_W-1];
							div_rem_d = '0;
							div_cnt_d = '0;
							state_d   = S_DIV;
						end
					end
					default: begin
						state_d = sym_q.last ? S_POP_F : S_IDLE;
					end
				endcase
			end
			S_DIV: begin
				div_rem_d = div_ge ? div_diff[WORD_W-1:0] : div_shift[WORD_W-1:0];
				div_quo_d = {div_quo_q[WORD_W-2:0], div_ge};
				div_cnt_d = div_cnt_q + DIV_CNT_W'(1);
				if (div_cnt_q == DIV_CNT_W'(WORD_W - 1)) begin
					state_d = S_DIV_FIX;
				end
			end
			S_DIV_FIX: begin
				res_d   = div_neg_q ? (WORD_W'(0) - div_quo_q) : div_quo_q;
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (!stack_full) begin
					ram_we  = 1'b1;
					count_d = count_q + CNT_W'(1);
				end else begin
					err_d = 1'b1;
				end
				state_d = sym_q.last ? S_POP_F : S_IDLE;
			end
			S_POP_F: begin
				if (stack_empty) begin
					b_d     = '0;
					err_d   = 1'b1;
					state_d = S_EMIT;
				end else begin
					count_d = cnt_dec;
					state_d = S_WAIT_F;
				end
			end
			S_WAIT_F: begin
				b_d     = ram_rdata;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				// Wait for the output register to free up, then reset the expression.
				if (!out_valid_q || !res_stall) begin
					out_d.value       = b_q;
					out_d.div_zero    = dz_q;
					out_d.stack_error = err_q;
					out_valid_d       = 1'b1;
					count_d           = '0;
					dz_d              = 1'b0;
					err_d             = 1'b0;
					state_d           = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dz_q        <= 1'b0;
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			count_q     <= count_d;
			dz_q        <= dz_d;
			err_q       <= err_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		sym_q     <= sym_d;
		a_q       <= a_d;
		b_q       <= b_d;
		res_q     <= res_d;
		div_rem_q <= div_rem_d;
		div_quo_q <= div_quo_d;
		div_mb_q  <= div_mb_d;
		div_neg_q <= div_neg_d;
		div_cnt_q <= div_cnt_d;
		out_q     <= out_d;
	end

	// The fill count never passes the stack depth.
	`PFX_ASSERT(a_count_range, clk, arst_n, count_q <= CNT_W'(STACK_DEPTH))
	// The divider only runs with a nonzero divisor.
	`PFX_ASSERT_IMPLY(a_div_nonzero, clk, arst_n, state_q == S_DIV, div_mb_q != '0)
	// Emitting a result empties the stack, clears the flags and shows the word.
	`PFX_ASSERT_NEXT(a_emit_clears, clk, arst_n, (state_q == S_EMIT) && (!out_valid_q || !res_stall), (count_q == '0) && !dz_q && !err_q && res_valid && (state_q == S_IDLE))

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none

// Self-checking testbench for the postfix expression evaluator.
//
// Symbol words go into the block through the sym channel and result words come
// back through the res channel. Both channels use valid and stall. A word moves
// at a rising edge where valid is high and stall is low. The testbench watches
// every symbol word that the block accepts and runs it through its own model of
// the evaluator. That model keeps a value stack, a depth count and the two
// sticky error flags. Every word with last set adds one expected result to a
// queue. Each result word that the block hands out is compared, field by field,
// with the oldest entry of that queue.
//
// The sender and the receiver both idle in random bursts, and a watchdog ends
// the run if nothing moves for too long.
module tb_top;

	import pfx_pkg::*;

	localparam int STACK_DEPTH    = 128;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 60;
	localparam int RANDOM_WORDS   = 1600;
	localparam int TOTAL_WORDS    = 1750;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic sym_valid = 1'b0;
	logic sym_stall;
	sym_t sym_data  = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;

	// These knobs control idling. A gap or a stall burst starts with a chance
	// of one in (odds + 1). In quiet mode neither side idles.
	bit quiet      = 1'b0;
	int gap_odds   = 5;
	int stall_odds = 5;

	int words_sent  = 0;
	int mismatches  = 0;
	int hold_cycles = 0;
	int idle_cycles = 0;

	// This is the evaluator model. It has its own stack, its own depth and its
	// own sticky flags.
	logic [31:0] eval_stack [STACK_DEPTH];
	int unsigned eval_depth      = 0;
	bit          saw_div_zero    = 1'b0;
	bit          saw_stack_error = 1'b0;
	res_t        pending_results [$];

	always #1 clk = ~clk;

	postfix_expression_evaluator_top #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sym_valid(sym_valid),
		.sym_stall(sym_stall),
		.sym_data (sym_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	function automatic logic [7:0] dig(int unsigned n);
		return SYM_ZERO + 8'(n);
	endfunction

	// A push onto a full stack is dropped and raises the stack error.
	function automatic void stack_push(logic [31:0] v);
		if (eval_depth < STACK_DEPTH) begin
			eval_stack[eval_depth] = v;
			eval_depth++;
		end else begin
			saw_stack_error = 1'b1;
		end
	endfunction

	// A pop from an empty stack returns zero and raises the stack error.
	function automatic logic [31:0] stack_pop();
		if (eval_depth == 0) begin
			saw_stack_error = 1'b1;
			return '0;
		end
		eval_depth--;
		return eval_stack[eval_depth];
	endfunction

	// The quotient truncates toward zero, and it is worked out on magnitudes.
	// The most negative value divided by -1 wraps back onto itself. Division
	// by zero gives zero and raises the flag.
	function automatic logic [31:0] div_toward_zero(logic [31:0] a, logic [31:0] b);
		logic [31:0] mag_a, mag_b, q;
		mag_a = a[31] ? -a : a;
		mag_b = b[31] ? -b : b;
		if (mag_b == 0) begin
			saw_div_zero = 1'b1;
			return '0;
		end
		q = mag_a / mag_b;
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	function automatic void evaluate_symbol(sym_t w);
		logic [31:0] a, b;
		res_t r;
		if (w.symbol >= SYM_ZERO && w.symbol <= SYM_NINE) begin
			stack_push(32'(w.symbol - SYM_ZERO));
		end else begin
			b = stack_pop();
			a = stack_pop();
			case (w.symbol)
				SYM_PLUS:  stack_push(a + b);
				SYM_MINUS: stack_push(a - b);
				SYM_STAR:  stack_push(a * b);
				SYM_SLASH: stack_push(div_toward_zero(a, b));
				default:   ;
			endcase
		end
		// The final pop comes after the symbol itself. Its underflow still
		// counts toward the flag of this expression.
		if (w.last) begin
			r.value       = stack_pop();
			r.div_zero    = saw_div_zero;
			r.stack_error = saw_stack_error;
			pending_results.push_back(r);
			eval_depth      = 0;
			saw_div_zero    = 1'b0;
			saw_stack_error = 1'b0;
		end
	endfunction

	function automatic void check_result(res_t got);
		res_t want;
		if (pending_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result word: value=%0d div_zero=%0b stack_error=%0b",
					got.value, got.div_zero, got.stack_error);
			return;
		end
		want = pending_results.pop_front();
		if (got.value !== want.value || got.div_zero !== want.div_zero ||
				got.stack_error !== want.stack_error) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result mismatch: expected value=%0d div_zero=%0b stack_error=%0b, %s",
					want.value, want.div_zero, want.stack_error,
					$sformatf("got value=%0d div_zero=%0b stack_error=%0b",
						got.value, got.div_zero, got.stack_error));
		end
	endfunction

	// Every accepted symbol word goes into the model. Every accepted result
	// word is checked against the model. Both are sampled at the clock edge,
	// so the values they see are the ones from before the edge.
	always @(posedge clk) begin
		if (arst_n && sym_valid === 1'b1 && sym_stall === 1'b0)
			evaluate_symbol(sym_data);
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0)
			check_result(res_data);
	end

	// The receiver stalls in random bursts.
	always @(posedge clk) begin
		if (hold_cycles > 0)
			hold_cycles--;
		else if (!quiet && arst_n && $urandom_range(0, stall_odds) == 0)
			hold_cycles = $urandom_range(1, 18);
		res_stall <= (hold_cycles > 0);
	end

	// The watchdog counts cycles in which no word moves on either channel.
	always @(posedge clk) begin
		if ((sym_valid === 1'b1 && sym_stall === 1'b0) ||
				(res_valid === 1'b1 && res_stall === 1'b0)) begin
			idle_cycles = 0;
		end else if (arst_n) begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// This task sends one symbol word. It may idle first for a random burst. It
	// then holds the word until the block takes it. Valid stays high from one
	// word to the next unless there is a gap between them.
	task automatic send_word(input logic [7:0] symbol, input bit last);
		sym_t w;
		int gap;
		w.symbol = symbol;
		w.last   = last;
		if (!quiet && $urandom_range(0, gap_odds) == 0) begin
			gap = $urandom_range(1, 18);
			sym_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sym_valid <= 1'b1;
		sym_data  <= w;
		do @(posedge clk); while (sym_stall !== 1'b0);
		words_sent++;
	endtask

	// The sender pauses until every expected result has come back. The wait at
	// the start lets the model take in the word that was just accepted.
	task automatic wait_drained();
		sym_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	// This task builds a random postfix expression with the given number of
	// operands, using random digits and operators. A broken expression swaps
	// some of its words for random bytes, so its stack use can come out wrong.
	task automatic send_expression(input int operands, input bit broken);
		int pushed, depth;
		logic [7:0] symbol;
		bit done;
		pushed = 0;
		depth  = 0;
		done   = 1'b0;
		while (!done) begin
			if (pushed < operands && (depth < 2 || $urandom_range(0, 1) == 1)) begin
				symbol = dig($urandom_range(0, 9));
				pushed++;
				depth++;
			end else begin
				case ($urandom_range(0, 6))
					0, 1:    symbol = SYM_PLUS;
					2, 3:    symbol = SYM_MINUS;
					4, 5:    symbol = SYM_STAR;
					default: symbol = SYM_SLASH;
				endcase
				depth--;
			end
			if (broken && $urandom_range(0, 5) == 0)
				symbol = 8'($urandom_range(0, 255));
			done = !(pushed < operands || depth > 1);
			send_word(symbol, done);
		end
	endtask

	// A lone digit is an expression by itself. This test uses both ends of
	// the digit range.
	task automatic test_digit_extremes();
		send_word(dig(0), 1'b1);
		send_word(dig(9), 1'b1);
		wait_drained();
	endtask

	// This test uses every operator in one expression, (0 - 7) / 2 + 9 * 8.
	// The division result is negative, so it checks truncation toward zero.
	task automatic test_all_operators();
		send_word(dig(0), 1'b0);
		send_word(dig(7), 1'b0);
		send_word(SYM_MINUS, 1'b0);
		send_word(dig(2), 1'b0);
		send_word(SYM_SLASH, 1'b0);
		send_word(dig(9), 1'b0);
		send_word(dig(8), 1'b0);
		send_word(SYM_STAR, 1'b0);
		send_word(SYM_PLUS, 1'b1);
		wait_drained();
	endtask

	// This test divides by zero. A clean expression follows it, which shows
	// that the flag was cleared.
	task automatic test_div_by_zero();
		send_word(dig(5), 1'b0);
		send_word(dig(0), 1'b0);
		send_word(SYM_SLASH, 1'b1);
		send_word(dig(3), 1'b1);
		wait_drained();
	endtask

	// This test builds 2 * 8^10, which wraps to the most negative value, and
	// divides it by -1.
	task automatic test_most_negative_div();
		repeat (10) send_word(dig(8), 1'b0);
		send_word(dig(2), 1'b0);
		repeat (10) send_word(SYM_STAR, 1'b0);
		send_word(dig(0), 1'b0);
		send_word(dig(1), 1'b0);
		send_word(SYM_MINUS, 1'b0);
		send_word(SYM_SLASH, 1'b1);
		wait_drained();
	endtask

	// Unknown symbols at both ends of the byte range pop from a stack that is
	// too shallow. The final pop then underflows as well.
	task automatic test_unknown_and_underflow();
		send_word(8'h00, 1'b1);
		send_word(dig(9), 1'b0);
		send_word(8'hFF, 1'b1);
		wait_drained();
	endtask

	// The first expression fills the stack exactly and then folds it with
	// additions, which must raise no error. The second pushes one digit past
	// full, so that digit is dropped.
	task automatic test_stack_limits();
		for (int i = 0; i < STACK_DEPTH; i++)
			send_word(dig($urandom_range(0, 9)), 1'b0);
		for (int i = 1; i < STACK_DEPTH; i++)
			send_word(SYM_PLUS, i == STACK_DEPTH - 1);
		for (int i = 0; i <= STACK_DEPTH; i++)
			send_word(dig($urandom_range(0, 9)), i == STACK_DEPTH);
		wait_drained();
	endtask

	// Most of the random part is well-formed expressions. The rest is broken
	// expressions and bursts of random bytes. Now and then the idling pattern
	// changes, and now and then the sender waits for the pipe to drain. A
	// steady run keeps the current pattern.
	task automatic test_random_expressions(input int target, input bit steady);
		int kind, operands;
		while (words_sent < target) begin
			kind     = $urandom_range(0, 19);
			operands = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24)
				: $urandom_range(1, 8);
			if (kind < 14) begin
				send_expression(operands, 1'b0);
			end else if (kind < 16) begin
				send_expression(operands, 1'b1);
			end else if (kind < 18) begin
				repeat ($urandom_range(1, 6))
					send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
			end else if (kind == 18) begin
				if (!steady) begin
					quiet      = ($urandom_range(0, 3) == 0);
					gap_odds   = $urandom_range(1, 30);
					stall_odds = $urandom_range(1, 30);
				end
			end else begin
				wait_drained();
			end
		end
	endtask

	// In the last part of the run neither side idles.
	task automatic test_steady_stream();
		quiet = 1'b1;
		test_random_expressions(TOTAL_WORDS, 1'b1);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_digit_extremes();
		test_all_operators();
		test_div_by_zero();
		test_most_negative_div();
		test_unknown_and_underflow();
		test_stack_limits();
		test_random_expressions(RANDOM_WORDS, 1'b0);
		test_steady_stream();

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire
